/* design/lfx_pkg.sv */
`timescale 1ns / 1ps
// shared types, opcodes and the opcode length function of the lda/ldx fuser
package lfx_pkg;

    localparam int WIN_BYTES   = 6;
    localparam int FIFO_DEPTH  = 4;
    localparam int COUNT_BITS  = 14;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 14'h3FFF;

    localparam logic [7:0] OP_NOP     = 8'hEA;
    localparam logic [7:0] OP_LDA_ABS = 8'hAD;
    localparam logic [7:0] OP_LDX_ABS = 8'hAE;
    localparam logic [7:0] OP_LAX_ABS = 8'hAF;
    localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
    localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
    localparam logic [7:0] OP_LAX_ZP  = 8'hA7;
    localparam logic [7:0] OP_LDA_ABY = 8'hB9;
    localparam logic [7:0] OP_LDX_ABY = 8'hBE;
    localparam logic [7:0] OP_LAX_ABY = 8'hBF;
    localparam logic [7:0] OP_BRK     = 8'h00;
    localparam logic [7:0] OP_JSR     = 8'h20;
    localparam logic [7:0] OP_RTI     = 8'h40;
    localparam logic [7:0] OP_RTS     = 8'h60;

    // one step's worth of rewritten bytes, handed from front to back
    typedef struct packed {
        logic [WIN_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      last;
        logic [COUNT_BITS-1:0]     fused;
    } t_group;

    // instruction length in bytes, always 1, 2 or 3
    function automatic logic [1:0] op_length(input logic [7:0] op);
        logic [3:0] lo;
        logic [3:0] hi;
        logic [1:0] len;
        lo = op[3:0];
        hi = op[7:4];
        if (lo == 4'h8 || lo == 4'hA || op == OP_BRK || op == OP_RTI || op == OP_RTS) begin
            len = 2'd1;
        end else if (op == OP_JSR) begin
            len = 2'd3;
        end else if (hi[0]) begin
            len = (lo == 4'h9 || lo >= 4'hB) ? 2'd3 : 2'd2;
        end else if (lo >= 4'hC) begin
            len = 2'd3;
        end else if (lo == 4'hB && (hi == 4'h8 || hi == 4'hA || hi == 4'hC)) begin
            len = 2'd3;
        end else begin
            len = 2'd2;
        end
        return len;
    endfunction

endpackage

/* design/lfx_front.sv */
`timescale 1ns / 1ps
// front end: six-byte window, instruction walk and pair fusion
module lfx_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_code_byte,
    input  logic            i_last_byte,
    output logic            o_grp_push,
    output lfx_pkg::t_group o_grp
);
    import lfx_pkg::*;

    logic [7:0]            r_win [WIN_BYTES];
    logic [7:0]            n_win [WIN_BYTES];
    logic [2:0]            r_fill;
    logic [2:0]            n_fill;
    logic [COUNT_BITS-1:0] r_fused;
    logic [COUNT_BITS-1:0] n_fused;

    logic [7:0]            w  [WIN_BYTES];
    logic [7:0]            wr [WIN_BYTES];
    logic [2:0]            fill;
    logic                  full_win;
    logic [1:0]            len0;
    logic                  abs_fuse;
    logic                  zp_fuse;
    logic [2:0]            k;
    logic [COUNT_BITS-1:0] fused_now;
    logic [2:0]            out_cnt;

    always_comb begin
        int j;
        for (int i = 0; i < WIN_BYTES; i++) begin
            w[i] = (r_fill == 3'(i)) ? i_code_byte : r_win[i];
        end
        fill     = r_fill + 3'd1;
        full_win = (fill == 3'(WIN_BYTES));
        len0     = op_length(w[0]);

        // abs and abs,y opcodes are three bytes long, so the partner sits at offset 3
        abs_fuse = (((w[0] == OP_LDA_ABS) && (w[3] == OP_LDX_ABS)) ||
                    ((w[0] == OP_LDX_ABS) && (w[3] == OP_LDA_ABS)) ||
                    ((w[0] == OP_LDA_ABY) && (w[3] == OP_LDX_ABY)) ||
                    ((w[0] == OP_LDX_ABY) && (w[3] == OP_LDA_ABY))) &&
                   (w[1] == w[4]) && (w[2] == w[5]);
        zp_fuse  = (((w[0] == OP_LDA_ZP) && (w[2] == OP_LDX_ZP)) ||
                    ((w[0] == OP_LDX_ZP) && (w[2] == OP_LDA_ZP))) &&
                   (w[1] == w[3]);

        for (int i = 0; i < WIN_BYTES; i++) begin
            wr[i] = w[i];
        end
        fused_now = r_fused;
        k         = 3'd0;
        if (full_win) begin
            if (abs_fuse) begin
                wr[0] = ((w[0] == OP_LDA_ABS) || (w[0] == OP_LDX_ABS)) ?
                        OP_LAX_ABS : OP_LAX_ABY;
                wr[3] = OP_NOP;
                wr[4] = OP_NOP;
                wr[5] = OP_NOP;
                k     = 3'd6;
            end else if (zp_fuse) begin
                wr[0] = OP_LAX_ZP;
                wr[2] = OP_NOP;
                wr[3] = OP_NOP;
                k     = 3'd4;
            end else begin
                k = {1'b0, len0};
            end
            if ((abs_fuse || zp_fuse) && (r_fused != COUNT_MAX)) begin
                fused_now = r_fused + COUNT_BITS'(1);
            end
        end

        out_cnt = i_last_byte ? fill : k;

        for (int i = 0; i < WIN_BYTES; i++) begin
            j = i + int'(k);
            n_win[i] = (j < WIN_BYTES) ? wr[3'(j)] : 8'h00;
        end
        n_fill  = fill - k;
        n_fused = fused_now;
        if (i_last_byte) begin
            n_fill  = 3'd0;
            n_fused = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_BYTES; i++) begin
            o_grp.bytes[i] = wr[i];
        end
        o_grp.cnt   = out_cnt;
        o_grp.last  = i_last_byte;
        o_grp.fused = fused_now;
        o_grp_push  = i_take && (out_cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= 3'd0;
            r_fused <= '0;
            for (int i = 0; i < WIN_BYTES; i++) begin
                r_win[i] <= 8'h00;
            end
        end else if (i_take) begin
            r_fill  <= n_fill;
            r_fused <= n_fused;
            for (int i = 0; i < WIN_BYTES; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

endmodule

/* design/lfx_queue.sv */
`timescale 1ns / 1ps
// short queue of rewritten groups between front and back
module lfx_queue #(
    parameter int DEPTH = lfx_pkg::FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lfx_pkg::t_group i_grp,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output lfx_pkg::t_group o_grp
);
    import lfx_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_grp   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* design/lfx_back.sv */
`timescale 1ns / 1ps
// back end: serializes one group at a time onto the result word port
module lfx_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  lfx_pkg::t_group                    i_q_grp,
    output logic                               o_q_pop,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic [7:0]                         o_out_byte,
    output logic                               o_out_last,
    output logic [lfx_pkg::COUNT_BITS-1:0]     o_fused_total
);
    import lfx_pkg::*;

    t_group     r_grp;
    logic [2:0] r_idx;
    logic       r_valid;
    logic       at_end;
    logic       done;
    logic       load;

    assign at_end  = (r_idx == (r_grp.cnt - 3'd1));
    assign done    = r_valid && i_pop && at_end;
    // refill in the same cycle the last word of a group leaves
    assign load    = i_q_valid && (!r_valid || done);
    assign o_q_pop = load;

    assign o_empty       = !r_valid;
    assign o_out_byte    = r_grp.bytes[r_idx];
    assign o_out_last    = r_grp.last && at_end;
    assign o_fused_total = r_grp.fused;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_grp <= i_q_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (r_valid && i_pop) begin
            r_idx <= r_idx + 3'd1;
        end
    end

endmodule

/* design/lda_ldx_lax_peephole_fuser.sv */
`timescale 1ns / 1ps
// lda/ldx to lax peephole fuser for a 6502 code byte stream
//
// Input channel: push/full. One code byte per word, last_byte marks the end
// of a region. Output channel: empty/pop. One rewritten byte per word, with
// out_last on the final byte of the region and the running fusion count.
// The front holds a six-byte window and, per accepted word, produces a group
// of zero to six rewritten bytes. Groups wait in a FIFO_DEPTH-entry queue;
// the back shifts each group out one word per cycle while pop is held high.
// Into an idle block, a group's first word shows once the group has been
// written into the queue and then loaded into the back's output register.
// One word per cycle on each side while full is low and pop is held high.
// The window can release up to six bytes at once (a fusion or the end of a
// region), so full may rise while short groups queue behind a long one even
// with pop held high; a stalled receiver fills the queue and holds full up.
// Reset empties the window, queue and output stage and clears the count;
// full and empty read low and high in the first cycle after reset.
// When the receiver holds pop low, the shown word stays put and the queue
// keeps absorbing groups until it is full.
module lda_ldx_lax_peephole_fuser #(
    parameter int FIFO_DEPTH = lfx_pkg::FIFO_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [7:0]                     i_code_byte,
    input  logic                           i_last_byte,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [7:0]                     o_out_byte,
    output logic                           o_out_last,
    output logic [lfx_pkg::COUNT_BITS-1:0] o_fused_total
);
    import lfx_pkg::*;

    logic   take;
    logic   grp_push;
    t_group grp_in;
    t_group grp_out;
    logic   q_valid;
    logic   q_pop;

    assign take = i_push && !o_full;

    lfx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_code_byte (i_code_byte),
        .i_last_byte (i_last_byte),
        .o_grp_push  (grp_push),
        .o_grp       (grp_in)
    );

    lfx_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (grp_push),
        .i_grp   (grp_in),
        .o_full  (o_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_grp   (grp_out)
    );

    lfx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_grp       (grp_out),
        .o_q_pop       (q_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_fused_total (o_fused_total)
    );

endmodule

/* design/lfx_port_checker.sv */
`timescale 1ns / 1ps
// port-level checks of the fuser, attached to the top level by bind
module lfx_port_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_full,
    input logic                           o_empty,
    input logic                           i_pop,
    input logic [7:0]                     o_out_byte,
    input logic                           o_out_last,
    input logic [lfx_pkg::COUNT_BITS-1:0] o_fused_total
);
    import lfx_pkg::*;

    // reset leaves nothing to pop and room to push
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("fuser not idle after reset");

    // a stalled word keeps its contents
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_byte) &&
                                  $stable(o_out_last) && $stable(o_fused_total)))
        else $error("stalled word changed");

    // within one region the fusion count never goes down
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_out_last) |=>
            (o_empty || (o_fused_total >= $past(o_fused_total))))
        else $error("fusion count decreased inside a region");

    // the count cannot jump by more than one fusion per word taken
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_out_last) |=>
            (o_empty || ((COUNT_BITS+1)'(o_fused_total) <=
                         (COUNT_BITS+1)'($past(o_fused_total)) + (COUNT_BITS+1)'(1))))
        else $error("fusion count jumped");

endmodule

bind lda_ldx_lax_peephole_fuser lfx_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_full        (o_full),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_out_byte    (o_out_byte),
    .o_out_last    (o_out_last),
    .o_fused_total (o_fused_total)
);

/* verif/lda_ldx_lax_peephole_fuser_test.sv */
`timescale 1ns / 1ps
// self-checking testbench of the lda/ldx to lax fuser with its own byte-stream predictor
module lda_ldx_lax_peephole_fuser_test;
    import lfx_pkg::*;

    typedef struct packed {
        logic [7:0]            data;
        logic                  last;
        logic [COUNT_BITS-1:0] fused;
    } t_rewritten_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_push;
    logic                  o_full;
    logic [7:0]            i_code_byte;
    logic                  i_last_byte;
    logic                  o_empty;
    logic                  i_pop;
    logic [7:0]            o_out_byte;
    logic                  o_out_last;
    logic [COUNT_BITS-1:0] o_fused_total;

    // predictor state
    logic [7:0]            held_bytes [0:WIN_BYTES-1];
    int                    held_count;
    logic [COUNT_BITS-1:0] fusion_count;
    t_rewritten_word       pending_words [$];

    // stimulus state and run statistics
    logic [7:0]            region_bytes [$];
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    bytes_sent;
    int                    regions_sent;
    int                    words_checked;
    int                    pairs_fused;
    int                    fail_count;

    lda_ldx_lax_peephole_fuser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_code_byte   (i_code_byte),
        .i_last_byte   (i_last_byte),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_fused_total (o_fused_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // 6502 instruction length from the opcode alone
    function automatic int instr_len(input logic [7:0] op);
        logic [3:0] lo;
        logic [3:0] hi;
        lo = op[3:0];
        hi = op[7:4];
        if (lo == 4'h8 || lo == 4'hA || op == OP_BRK || op == OP_RTI || op == OP_RTS)
            return 1;
        if (op == OP_JSR)
            return 3;
        if (hi[0])
            return (lo == 4'h9 || lo >= 4'hB) ? 3 : 2;
        if (lo >= 4'hC)
            return 3;
        if (lo == 4'hB && (hi == 4'h8 || hi == 4'hA || hi == 4'hC))
            return 3;
        return 2;
    endfunction

    function automatic bit is_abs_pair(input logic [7:0] op0, input logic [7:0] op1);
        return (op0 == OP_LDA_ABS && op1 == OP_LDX_ABS)
            || (op0 == OP_LDX_ABS && op1 == OP_LDA_ABS)
            || (op0 == OP_LDA_ABY && op1 == OP_LDX_ABY)
            || (op0 == OP_LDX_ABY && op1 == OP_LDA_ABY);
    endfunction

    function automatic bit is_zp_pair(input logic [7:0] op0, input logic [7:0] op1);
        return (op0 == OP_LDA_ZP && op1 == OP_LDX_ZP) || (op0 == OP_LDX_ZP && op1 == OP_LDA_ZP);
    endfunction

    task automatic count_fusion();
        pairs_fused++;
        if (fusion_count < COUNT_MAX)
            fusion_count++;
    endtask

    // work out the rewritten bytes that one accepted code byte releases
    task automatic rewrite_code_byte(input logic [7:0] b, input logic lst);
        logic [7:0]      step_bytes [$];
        logic [7:0]      op0;
        logic [7:0]      op1;
        int              len0;
        int              take;
        t_rewritten_word w;
        held_bytes[held_count] = b;
        held_count++;
        if (held_count == WIN_BYTES) begin
            op0  = held_bytes[0];
            len0 = instr_len(op0);
            op1  = held_bytes[len0];
            if (is_abs_pair(op0, op1) && held_bytes[1] == held_bytes[4]
                    && held_bytes[2] == held_bytes[5]) begin
                held_bytes[0] = (op0 == OP_LDA_ABS || op0 == OP_LDX_ABS) ? OP_LAX_ABS : OP_LAX_ABY;
                held_bytes[3] = OP_NOP;
                held_bytes[4] = OP_NOP;
                held_bytes[5] = OP_NOP;
                count_fusion();
                take = 6;
            end else if (is_zp_pair(op0, op1) && held_bytes[1] == held_bytes[3]) begin
                held_bytes[0] = OP_LAX_ZP;
                held_bytes[2] = OP_NOP;
                held_bytes[3] = OP_NOP;
                count_fusion();
                take = 4;
            end else begin
                take = len0;
            end
            for (int i = 0; i < take; i++)
                step_bytes.push_back(held_bytes[i]);
            for (int i = 0; i < WIN_BYTES - take; i++)
                held_bytes[i] = held_bytes[i + take];
            held_count = WIN_BYTES - take;
        end
        if (lst) begin
            for (int i = 0; i < held_count; i++)
                step_bytes.push_back(held_bytes[i]);
        end
        foreach (step_bytes[i]) begin
            w.data  = step_bytes[i];
            w.last  = lst && (i == step_bytes.size() - 1);
            w.fused = fusion_count;
            pending_words.push_back(w);
        end
        if (lst) begin
            foreach (held_bytes[i])
                held_bytes[i] = 8'h00;
            held_count   = 0;
            fusion_count = '0;
            regions_sent++;
        end
    endtask

    // one code byte through the push side, with random gaps before it
    task automatic send_code_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push      <= 1'b1;
        i_code_byte <= b;
        i_last_byte <= lst;
        do
            @(posedge i_clk);
        while (o_full);
        bytes_sent++;
        rewrite_code_byte(b, lst);
    endtask

    task automatic send_region();
        foreach (region_bytes[i])
            send_code_byte(region_bytes[i], i == region_bytes.size() - 1);
    endtask

    // hold off the push side until every rewritten byte has come out
    task automatic wait_drained();
        i_push <= 1'b0;
        while (pending_words.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic note_failure(input string what, input t_rewritten_word exp_w);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected byte %02h last %0b fused %0d, %s %02h last %0b fused %0d",
                     $realtime, what, exp_w.data, exp_w.last, exp_w.fused,
                     "got byte", o_out_byte, o_out_last, o_fused_total);
    endtask

    // pop side: check each accepted word, then pick pop for the next cycle
    initial begin
        t_rewritten_word w;
        i_pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) begin
                words_checked++;
                if (pending_words.size() == 0) begin
                    w = '0;
                    note_failure("word with nothing expected", w);
                end else begin
                    w = pending_words.pop_front();
                    if (o_out_byte !== w.data || o_out_last !== w.last
                            || o_fused_total !== w.fused)
                        note_failure("mismatch", w);
                end
            end
            i_pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // pair of loads with random operands, sometimes with a mismatched operand
    task automatic add_load_pair();
        logic [7:0] op_a;
        logic [7:0] op_x;
        logic [7:0] lo_b;
        logic [7:0] hi_b;
        logic [7:0] lo_2;
        logic [7:0] hi_2;
        int         kind;
        bit         swap;
        kind = $urandom_range(2);
        swap = 1'($urandom_range(1));
        lo_b = 8'($urandom_range(255));
        hi_b = 8'($urandom_range(255));
        lo_2 = lo_b;
        hi_2 = hi_b;
        if ($urandom_range(99) < 15) begin
            if (kind != 1 && $urandom_range(1))
                hi_2 = hi_b ^ (8'h01 << $urandom_range(7));
            else
                lo_2 = lo_b ^ (8'h01 << $urandom_range(7));
        end
        case (kind)
            0: begin op_a = OP_LDA_ABS; op_x = OP_LDX_ABS; end
            1: begin op_a = OP_LDA_ZP;  op_x = OP_LDX_ZP;  end
            default: begin op_a = OP_LDA_ABY; op_x = OP_LDX_ABY; end
        endcase
        region_bytes.push_back(swap ? op_x : op_a);
        region_bytes.push_back(lo_b);
        if (kind != 1)
            region_bytes.push_back(hi_b);
        region_bytes.push_back(swap ? op_a : op_x);
        region_bytes.push_back(lo_2);
        if (kind != 1)
            region_bytes.push_back(hi_2);
    endtask

    task automatic make_random_region();
        logic [7:0] op;
        int         target;
        int         pick;
        int         n;
        target = ($urandom_range(7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        region_bytes.delete();
        while (region_bytes.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                add_load_pair();
            end else if (pick < 75) begin
                op = 8'($urandom_range(255));
                n  = instr_len(op);
                region_bytes.push_back(op);
                for (int i = 1; i < n; i++)
                    region_bytes.push_back(8'($urandom_range(255)));
            end else begin
                region_bytes.push_back(8'($urandom_range(255)));
            end
        end
        while (region_bytes.size() > target)
            void'(region_bytes.pop_back());
    endtask

    task automatic test_short_regions();
        region_bytes = '{8'hFF};
        send_region();
        region_bytes = '{OP_BRK, OP_LDA_ABS, 8'h34, 8'h12, OP_LDX_ABS};
        send_region();
        wait_drained();
    endtask

    // every pair kind, the last pair completing on the final byte
    task automatic test_pair_fusions();
        region_bytes = '{OP_LDA_ABS, 8'h55, 8'hAA, OP_LDX_ABS, 8'h55, 8'hAA,
                         OP_LDA_ZP, 8'h80, OP_LDX_ZP, 8'h80,
                         OP_LDX_ABY, 8'h01, 8'hFE, OP_LDA_ABY, 8'h01, 8'hFE};
        send_region();
        wait_drained();
    endtask

    task automatic test_operand_mismatch();
        region_bytes = '{OP_LDA_ZP, 8'h10, OP_LDX_ZP, 8'h11, OP_RTS, OP_JSR};
        send_region();
        wait_drained();
    endtask

    task automatic test_random_regions(input int send_pct, input int recv_pct, input int n_items);
        int start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            make_random_region();
            send_region();
        end
        wait_drained();
    endtask

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        foreach (held_bytes[i])
            held_bytes[i] = 8'h00;
        held_count      = 0;
        fusion_count    = '0;
        bytes_sent      = 0;
        regions_sent    = 0;
        words_checked   = 0;
        pairs_fused     = 0;
        fail_count      = 0;
        send_idle_pct   = 33;
        recv_idle_pct   = 58;
        i_rst_n     <= 1'b0;
        i_push      <= 1'b0;
        i_code_byte <= 8'h00;
        i_last_byte <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_regions();
        test_pair_fusions();
        test_operand_mismatch();
        test_random_regions(33, 58, 55);
        test_random_regions(58, 33, 55);
        test_random_regions(0, 0, 55);

        if (pending_words.size() > 0) begin
            fail_count += pending_words.size();
            $display("%0d rewritten bytes never came out", pending_words.size());
        end
        $display("run covered %0d code bytes in %0d regions, %0d output words checked",
                 bytes_sent, regions_sent, words_checked);
        $display("%0d load pairs fused across short, fused, mismatched and random regions",
                 pairs_fused);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* lda_ldx_lax_peephole_fuser.f */
design/lfx_pkg.sv
design/lfx_front.sv
design/lfx_queue.sv
design/lfx_back.sv
design/lda_ldx_lax_peephole_fuser.sv
design/lfx_port_checker.sv
verif/lda_ldx_lax_peephole_fuser_test.sv
